// ===== hdl/lfr_pkg.sv =====
// Package for the LFU frame replacement block: default parameter values,
// field widths, register map codes and the enumerated types used by the cell and the top level.
// Depends on nothing; every other file refers to it by scoped names.
package lfr_pkg;

  localparam int DEF_SLOTS      = 32;
  localparam int DEF_ID_BITS    = 8;
  localparam int DEF_COUNT_BITS = 16;

  // Fixed widths of the result slot index and the frame size register.
  localparam int SLOT_INDEX_W = 5;
  localparam int FRAME_SIZE_W = 6;

  localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_RESET = 6'd32;

  // APB-style register port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register word index of frame_size (byte address divided by four).
  localparam logic [APB_ADDR_W-3:0] REG_FRAME_SIZE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_HIT,
    CMD_APPEND,
    CMD_EVICT
  } cmd_kind_t;

endpackage

// ===== hdl/lfr_if.sv =====
// Valid/ready channel interfaces for the request and result sides of the
// LFU frame replacement block. Depends on lfr_pkg for default widths.
interface lfr_in_if #(
  parameter int ID_BITS = lfr_pkg::DEF_ID_BITS
);
  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] candidate_id;

  modport source (output valid, output candidate_id, input ready);
  modport sink (input valid, input candidate_id, output ready);
endinterface

interface lfr_out_if #(
  parameter int ID_BITS    = lfr_pkg::DEF_ID_BITS,
  parameter int COUNT_BITS = lfr_pkg::DEF_COUNT_BITS
);
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [lfr_pkg::SLOT_INDEX_W-1:0] slot_index;
  logic                            evicted_valid;
  logic [ID_BITS-1:0]              evicted_id;
  logic [COUNT_BITS-1:0]           new_count;

  modport source (output valid, output hit, output slot_index, output evicted_valid,
                  output evicted_id, output new_count, input ready);
  modport sink (input valid, input hit, input slot_index, input evicted_valid,
                input evicted_id, input new_count, output ready);
endinterface

// ===== hdl/lfr_cell.sv =====
// One slot cell of the LFU frame: holds a slot's valid bit, id and vote count,
// folds itself into the search token passed along the chain, and applies updates.
// Depends on lfr_pkg for the update command codes.
module lfr_cell #(
  parameter int SLOTS      = lfr_pkg::DEF_SLOTS,
  parameter int ID_BITS    = lfr_pkg::DEF_ID_BITS,
  parameter int COUNT_BITS = lfr_pkg::DEF_COUNT_BITS,
  parameter int K          = 0,
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int TOK_W     = 2 + 2 * IDX_W + 2 * COUNT_BITS + ID_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [ID_BITS-1:0]    key,
  input  logic [TOK_W-1:0]      tok_i,
  output logic [TOK_W-1:0]      tok_o,
  input  lfr_pkg::cmd_kind_t    cmd_kind,
  input  logic [IDX_W-1:0]      cmd_idx,
  input  logic [IDX_W-1:0]      cmd_last,
  input  logic [ID_BITS-1:0]    cmd_id,
  input  logic                  nb_valid,
  input  logic [ID_BITS-1:0]    nb_id,
  input  logic [COUNT_BITS-1:0] nb_votes,
  output logic                  valid_o,
  output logic [ID_BITS-1:0]    id_o,
  output logic [COUNT_BITS-1:0] votes_o
);

  typedef struct packed {
    logic                  found;
    logic [IDX_W-1:0]      match_idx;
    logic [COUNT_BITS-1:0] match_votes;
    logic                  have_min;
    logic [IDX_W-1:0]      min_idx;
    logic [COUNT_BITS-1:0] min_votes;
    logic [ID_BITS-1:0]    min_id;
  } token_t;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(K);

  token_t                tin;
  token_t                tok_nxt;
  token_t                tok_r;
  logic                  valid_r;
  logic                  valid_nxt;
  logic [ID_BITS-1:0]    id_r;
  logic [ID_BITS-1:0]    id_nxt;
  logic [COUNT_BITS-1:0] votes_r;
  logic [COUNT_BITS-1:0] votes_nxt;

  assign tin = token_t'(tok_i);

  // Search step: first matching slot, and the strictly smaller count wins so
  // that the oldest slot keeps a tie.
  always_comb begin
    tok_nxt = tin;
    if (valid_r && !tin.found && (id_r == key)) begin
      tok_nxt.found       = 1'b1;
      tok_nxt.match_idx   = MY_IDX;
      tok_nxt.match_votes = votes_r;
    end
    if (valid_r && (!tin.have_min || (votes_r < tin.min_votes))) begin
      tok_nxt.have_min  = 1'b1;
      tok_nxt.min_idx   = MY_IDX;
      tok_nxt.min_votes = votes_r;
      tok_nxt.min_id    = id_r;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    votes_nxt = votes_r;
    case (cmd_kind)
      lfr_pkg::CMD_HIT: begin
        if (MY_IDX == cmd_idx && votes_r != {COUNT_BITS{1'b1}}) begin
          votes_nxt = votes_r + COUNT_BITS'(1);
        end
      end
      lfr_pkg::CMD_APPEND: begin
        if (MY_IDX == cmd_idx) begin
          valid_nxt = 1'b1;
          id_nxt    = cmd_id;
          votes_nxt = COUNT_BITS'(1);
        end
      end
      lfr_pkg::CMD_EVICT: begin
        if (MY_IDX == cmd_last) begin
          valid_nxt = 1'b1;
          id_nxt    = cmd_id;
          votes_nxt = COUNT_BITS'(1);
        end else if (MY_IDX >= cmd_idx && MY_IDX < cmd_last) begin
          valid_nxt = nb_valid;
          id_nxt    = nb_id;
          votes_nxt = nb_votes;
        end
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      votes_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      votes_r <= votes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    tok_r <= tok_nxt;
  end

  assign tok_o   = tok_r;
  assign valid_o = valid_r;
  assign id_o    = id_r;
  assign votes_o = votes_r;

endmodule

// ===== hdl/lfu_frame_replacement_top.sv =====
// Top level of the LFU frame replacement block: control sequencer, occupancy,
// frame size register, result register and the chain of slot cells.
// Depends on lfr_pkg, the channel interfaces in lfr_if.sv and lfr_cell.
//
// Usage: each transfer on in_chan presents one candidate id. The block looks it
// up in its frame of slots (slot 0 is the oldest) and returns exactly one result
// transfer on out_chan: whether it was a hit, the slot the id now holds, whether
// and which id was evicted, and the id's vote count after the step.
// A search token walks the chain of slot cells one cell per cycle, gathering the
// first matching slot and the least-voted slot (oldest on a tie); then the apply
// step updates the cells, shifting later slots down on an eviction.
// The result is loaded into the output register in the apply step, and a new
// request is taken only once the block is back in idle, so it takes no new
// request before the last one has been through search and apply.
// The result sits in an output register, so the next request is accepted while
// a result still waits; if the receiver stalls, the next request finishes its
// search and then holds in the apply cycle until the output register is free.
// Reset (rst_n low, synchronous) empties the frame and sets frame_size to 32.
// frame_size is written over the APB-style port at byte address 0, by the user only
// while idle (the block does not enforce it); zero acts as one, above SLOTS as SLOTS.
module lfu_frame_replacement_top #(
  parameter int SLOTS      = lfr_pkg::DEF_SLOTS,
  parameter int ID_BITS    = lfr_pkg::DEF_ID_BITS,
  parameter int COUNT_BITS = lfr_pkg::DEF_COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  lfr_in_if.sink                           in_chan,
  lfr_out_if.source                        out_chan,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lfr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lfr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lfr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OCC_W = $clog2(SLOTS + 1);
  localparam int TOK_W = 2 + 2 * IDX_W + 2 * COUNT_BITS + ID_BITS;
  localparam int CMP_W = ((OCC_W > lfr_pkg::FRAME_SIZE_W) ? OCC_W : lfr_pkg::FRAME_SIZE_W) + 1;
  localparam int SI_W  = lfr_pkg::SLOT_INDEX_W;

  // Same layout as the token inside each cell.
  typedef struct packed {
    logic                  found;
    logic [IDX_W-1:0]      match_idx;
    logic [COUNT_BITS-1:0] match_votes;
    logic                  have_min;
    logic [IDX_W-1:0]      min_idx;
    logic [COUNT_BITS-1:0] min_votes;
    logic [ID_BITS-1:0]    min_id;
  } token_t;

  // Control state.
  lfr_pkg::state_t                  state_r;
  lfr_pkg::state_t                  state_nxt;
  logic [IDX_W-1:0]                 cnt_r;
  logic [IDX_W-1:0]                 cnt_nxt;
  logic [OCC_W-1:0]                 occ_r;
  logic [OCC_W-1:0]                 occ_nxt;
  logic [lfr_pkg::FRAME_SIZE_W-1:0] frame_size_r;
  logic [ID_BITS-1:0]               cand_r;

  // Result register.
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  hit_r;
  logic [SI_W-1:0]       slot_index_r;
  logic                  evicted_valid_r;
  logic [ID_BITS-1:0]    evicted_id_r;
  logic [COUNT_BITS-1:0] new_count_r;

  // Chain wiring; entry SLOTS of the state arrays is the empty neighbour of the last cell.
  logic [TOK_W-1:0]      tok_w [0:SLOTS];
  logic                  st_valid [0:SLOTS];
  logic [ID_BITS-1:0]    st_id [0:SLOTS];
  logic [COUNT_BITS-1:0] st_votes [0:SLOTS];

  token_t                tok_end;
  lfr_pkg::cmd_kind_t    cmd_kind;
  logic [IDX_W-1:0]      cmd_idx;
  logic [IDX_W-1:0]      cmd_last;
  logic                  load_out;
  logic                  res_hit;
  logic [IDX_W-1:0]      res_idx;
  logic                  res_ev_valid;
  logic [ID_BITS-1:0]    res_ev_id;
  logic [COUNT_BITS-1:0] res_count;
  logic [CMP_W-1:0]      eff_size;
  logic [CMP_W-1:0]      fs_ext;
  logic                  has_room;
  logic [IDX_W+SI_W-1:0] idx_wide;
  logic                  cfg_wr;
  logic                  reg_sel;

  // Register port. Writes complete in the access cycle; pready is always high.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[lfr_pkg::APB_ADDR_W-1:2] == lfr_pkg::REG_FRAME_SIZE);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? lfr_pkg::APB_DATA_W'(frame_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r <= lfr_pkg::FRAME_SIZE_RESET;
    end else if (cfg_wr) begin
      frame_size_r <= pwdata[lfr_pkg::FRAME_SIZE_W-1:0];
    end
  end

  // Effective frame size: zero counts as one, and it never exceeds the slot count.
  always_comb begin
    fs_ext = CMP_W'(frame_size_r);
    if (fs_ext == '0) begin
      eff_size = CMP_W'(1);
    end else if (fs_ext > CMP_W'(SLOTS)) begin
      eff_size = CMP_W'(SLOTS);
    end else begin
      eff_size = fs_ext;
    end
  end

  assign has_room = CMP_W'(occ_r) < eff_size;

  // The search token enters the first cell empty; the key is broadcast to all cells.
  assign tok_w[0]        = '0;
  assign st_valid[SLOTS] = 1'b0;
  assign st_id[SLOTS]    = '0;
  assign st_votes[SLOTS] = '0;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    lfr_cell #(
      .SLOTS      (SLOTS),
      .ID_BITS    (ID_BITS),
      .COUNT_BITS (COUNT_BITS),
      .K          (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .key      (cand_r),
      .tok_i    (tok_w[k]),
      .tok_o    (tok_w[k+1]),
      .cmd_kind (cmd_kind),
      .cmd_idx  (cmd_idx),
      .cmd_last (cmd_last),
      .cmd_id   (cand_r),
      .nb_valid (st_valid[k+1]),
      .nb_id    (st_id[k+1]),
      .nb_votes (st_votes[k+1]),
      .valid_o  (st_valid[k]),
      .id_o     (st_id[k]),
      .votes_o  (st_votes[k])
    );
  end

  assign tok_end = token_t'(tok_w[SLOTS]);

  // Decision on the token that has passed every cell. While the apply cycle
  // waits for the output register, the chain keeps recomputing the same token.
  always_comb begin
    res_hit      = 1'b0;
    res_ev_valid = 1'b0;
    res_ev_id    = '0;
    res_count    = COUNT_BITS'(1);
    cmd_idx      = tok_end.min_idx;
    cmd_last     = IDX_W'(occ_r - OCC_W'(1));
    occ_nxt      = occ_r;
    if (tok_end.found) begin
      res_hit = 1'b1;
      cmd_idx = tok_end.match_idx;
      if (tok_end.match_votes != {COUNT_BITS{1'b1}}) begin
        res_count = tok_end.match_votes + COUNT_BITS'(1);
      end else begin
        res_count = tok_end.match_votes;
      end
      res_idx = tok_end.match_idx;
    end else if (has_room) begin
      cmd_idx = IDX_W'(occ_r);
      res_idx = IDX_W'(occ_r);
      occ_nxt = occ_r + OCC_W'(1);
    end else begin
      res_ev_valid = 1'b1;
      res_ev_id    = tok_end.min_id;
      res_idx      = cmd_last;
    end
    if (!load_out) begin
      occ_nxt = occ_r;
    end
  end

  // Sequencer: idle, walk the chain, then apply and report.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    load_out      = 1'b0;
    cmd_kind      = lfr_pkg::CMD_NONE;
    in_chan.ready = 1'b0;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    case (state_r)
      lfr_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          cnt_nxt   = '0;
          state_nxt = lfr_pkg::ST_SCAN;
        end
      end
      lfr_pkg::ST_SCAN: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = lfr_pkg::ST_APPLY;
        end
      end
      lfr_pkg::ST_APPLY: begin
        if (!out_valid_r || out_chan.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lfr_pkg::ST_IDLE;
          if (tok_end.found) begin
            cmd_kind = lfr_pkg::CMD_HIT;
          end else if (has_room) begin
            cmd_kind = lfr_pkg::CMD_APPEND;
          end else begin
            cmd_kind = lfr_pkg::CMD_EVICT;
          end
        end
      end
      default: begin
        state_nxt = lfr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfr_pkg::ST_IDLE;
      cnt_r       <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The slot index is reported in its low five bits.
  assign idx_wide = {{SI_W{1'b0}}, res_idx};

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      cand_r <= in_chan.candidate_id;
    end
    if (load_out) begin
      hit_r           <= res_hit;
      slot_index_r    <= idx_wide[SI_W-1:0];
      evicted_valid_r <= res_ev_valid;
      evicted_id_r    <= res_ev_id;
      new_count_r     <= res_count;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.hit           = hit_r;
  assign out_chan.slot_index    = slot_index_r;
  assign out_chan.evicted_valid = evicted_valid_r;
  assign out_chan.evicted_id    = evicted_id_r;
  assign out_chan.new_count     = new_count_r;

endmodule

// ===== dv/lfu_frame_replacement_top_tb.sv =====
// Self-checking testbench for lfu_frame_replacement_top: drives candidate ids and frame sizes,
// predicts every result transfer with its own LFU frame model and compares field by field.
// Depends on lfr_pkg, the channel interfaces in lfr_if.sv and the block's top level.
module lfu_frame_replacement_top_tb;

  localparam int SLOTS   = lfr_pkg::DEF_SLOTS;
  localparam int ID_W    = lfr_pkg::DEF_ID_BITS;
  localparam int COUNT_W = lfr_pkg::DEF_COUNT_BITS;
  localparam int IDX_W   = lfr_pkg::SLOT_INDEX_W;
  localparam int SIZE_W  = lfr_pkg::FRAME_SIZE_W;

  // Byte address of the frame size register: word index shifted past the byte lanes.
  localparam logic [lfr_pkg::APB_ADDR_W-1:0] FRAME_SIZE_ADDR = {lfr_pkg::REG_FRAME_SIZE, 2'b00};

  // Width of the window of ids that the random traffic mostly draws from. It is a little
  // wider than the frame, so that hits, appends and evictions all stay frequent.
  localparam int ID_WINDOW = 40;

  // Depth of the ring of predictions; no more than two requests are ever outstanding.
  localparam int PRED_DEPTH = 8;

  // One result transfer as the block reports it.
  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   slot_index;
    logic               evicted_valid;
    logic [ID_W-1:0]    evicted_id;
    logic [COUNT_W-1:0] new_count;
  } frame_outcome_t;

  logic clk;
  logic rst_n;

  // Configuration port.
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [lfr_pkg::APB_ADDR_W-1:0]  paddr;
  logic [lfr_pkg::APB_DATA_W-1:0]  pwdata;
  logic [lfr_pkg::APB_DATA_W-1:0]  prdata;
  logic                            pready;

  lfr_in_if  #(.ID_BITS(ID_W))                      in_chan ();
  lfr_out_if #(.ID_BITS(ID_W), .COUNT_BITS(COUNT_W)) out_chan ();

  lfu_frame_replacement_top #(
    .SLOTS(SLOTS),
    .ID_BITS(ID_W),
    .COUNT_BITS(COUNT_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Shadow of the block's frame. Valid slots are always 0 .. frame_fill-1, oldest first, so
  // no separate valid flag is kept and an id is only ever read once it has been written.
  logic [ID_W-1:0]    frame_id    [SLOTS];
  logic [COUNT_W-1:0] frame_votes [SLOTS];
  int                 frame_fill;
  logic [SIZE_W-1:0]  frame_size_setting;

  // Outcomes predicted for accepted requests, oldest first, awaiting their result transfer.
  // The head index is advanced by the result side and the tail index by the request side.
  frame_outcome_t predicted_outcomes [PRED_DEPTH];
  int             pred_head;
  int             pred_tail;

  int fault_count;

  // When clear, neither side idles: this gives long stretches of back-to-back transfers.
  bit gaps_enabled;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. A correct run makes some 500 requests, plus idling, stalls and register
  // writes; the limit below lies well beyond the time that such a run takes.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Works out the result of one accepted request and updates the shadow frame.
  // A hit bumps the vote count, saturating at the largest count. A miss with room appends
  // the id as the newest slot. A miss when full evicts the least-voted slot, the oldest one
  // winning a tie, shifts every later slot down by one and appends the id as the newest.
  // The frame size register reads zero as one and anything above SLOTS as SLOTS; when it has
  // been lowered below the fill, misses keep evicting from all occupied slots.
  function automatic frame_outcome_t lookup_frame(input logic [ID_W-1:0] id);
    frame_outcome_t res;
    int             hit_pos;
    int             victim;
    int             room;
    int             i;
    res     = '0;
    hit_pos = -1;
    for (i = 0; i < frame_fill; i++) begin
      if (hit_pos < 0 && frame_id[i] == id) hit_pos = i;
    end
    room = int'(frame_size_setting);
    if (room == 0) room = 1;
    if (room > SLOTS) room = SLOTS;

    if (hit_pos >= 0) begin
      if (frame_votes[hit_pos] != {COUNT_W{1'b1}}) frame_votes[hit_pos] += 1'b1;
      res.hit        = 1'b1;
      res.slot_index = IDX_W'(hit_pos);
      res.new_count  = frame_votes[hit_pos];
    end else if (frame_fill < room) begin
      frame_id[frame_fill]    = id;
      frame_votes[frame_fill] = COUNT_W'(1);
      res.slot_index          = IDX_W'(frame_fill);
      res.new_count           = COUNT_W'(1);
      frame_fill++;
    end else begin
      victim = 0;
      for (i = 1; i < frame_fill; i++) begin
        if (frame_votes[i] < frame_votes[victim]) victim = i;
      end
      res.evicted_valid = 1'b1;
      res.evicted_id    = frame_id[victim];
      for (i = victim; i + 1 < frame_fill; i++) begin
        frame_id[i]    = frame_id[i + 1];
        frame_votes[i] = frame_votes[i + 1];
      end
      frame_id[frame_fill - 1]    = id;
      frame_votes[frame_fill - 1] = COUNT_W'(1);
      res.slot_index              = IDX_W'(frame_fill - 1);
      res.new_count               = COUNT_W'(1);
    end
    return res;
  endfunction

  // Offers one candidate id and waits for the transfer. The caller is always just past a
  // rising edge. A random gap may come first; valid is not lowered between back-to-back
  // requests, so it gets a single assignment in every time step.
  task automatic offer_candidate(input logic [ID_W-1:0] id);
    while (gaps_enabled && $urandom_range(99) < 8) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.candidate_id <= id;
    // Just after the edge, ready still holds the value that the edge sampled.
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    predicted_outcomes[pred_tail % PRED_DEPTH] = lookup_frame(id);
    pred_tail++;
  endtask

  // Stops offering requests and waits until every predicted result has been seen, then lets
  // one full search of the cell chain pass so that the block is surely idle.
  task automatic settle_frame();
    in_chan.valid <= 1'b0;
    while (pred_tail != pred_head) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);
  endtask

  // Writes the frame size register once the block is idle: a setup cycle, then an access
  // cycle that completes at the edge where pready is high.
  task automatic program_frame_size(input logic [SIZE_W-1:0] size);
    settle_frame();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FRAME_SIZE_ADDR;
    pwdata  <= lfr_pkg::APB_DATA_W'(size);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    frame_size_setting = size;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly ids from a narrow window, so that the frame sees a rich mix of hits and
  // evictions, with some ids drawn from the whole range.
  function automatic logic [ID_W-1:0] pick_candidate(input int window_base);
    if ($urandom_range(99) < 15) return ID_W'($urandom_range((1 << ID_W) - 1));
    return ID_W'(window_base + $urandom_range(ID_WINDOW - 1));
  endfunction

  // Frame size zero acts as a single slot: the second distinct id already evicts the first,
  // and a hit on the only slot still counts up.
  task automatic test_size_zero();
    program_frame_size('0);
    offer_candidate(8'h00);
    offer_candidate(8'hFF);
    offer_candidate(8'hFF);
    offer_candidate(8'h5A);
  endtask

  // With two slots, a miss first evicts the oldest of two equal counts, then the newer slot
  // once the older one has gathered more votes.
  task automatic test_tie_break();
    program_frame_size(SIZE_W'(2));
    offer_candidate(8'h01);
    offer_candidate(8'h02);
    offer_candidate(8'h01);
    offer_candidate(8'h03);
  endtask

  // The largest register value is clamped to the number of slots, so misses keep appending.
  task automatic test_size_above_slots();
    program_frame_size({SIZE_W{1'b1}});
    offer_candidate(8'h10);
    offer_candidate(8'h11);
    offer_candidate(8'h12);
    offer_candidate(8'h80);
    offer_candidate(8'h7F);
  endtask

  // Lowering the size below the fill drops nothing; misses evict from all occupied slots
  // and the fill stays where it is.
  task automatic test_size_below_occupancy();
    program_frame_size(SIZE_W'(3));
    offer_candidate(8'h01);
    offer_candidate(8'h20);
    offer_candidate(8'h21);
  endtask

  // Random traffic in phases with different frame sizes, including both extremes. The
  // fourth phase runs without any idling on either side.
  task automatic test_random_traffic(input int per_phase);
    logic [SIZE_W-1:0] sizes [5];
    int                window_base;
    int                phase;
    int                n;
    sizes[0] = SIZE_W'(SLOTS);
    sizes[1] = SIZE_W'(1);
    sizes[2] = SIZE_W'($urandom_range((1 << SIZE_W) - 1));
    sizes[3] = {SIZE_W{1'b1}};
    sizes[4] = SIZE_W'(SLOTS);
    for (phase = 0; phase < 5; phase++) begin
      program_frame_size(sizes[phase]);
      gaps_enabled = (phase != 3);
      window_base  = $urandom_range((1 << ID_W) - ID_WINDOW);
      for (n = 0; n < per_phase; n++) offer_candidate(pick_candidate(window_base));
    end
    gaps_enabled = 1'b1;
  endtask

  // Hammers the oldest held id with a run of back-to-back hits, so that one slot gathers
  // far more votes than the rest and is passed over by later evictions.
  task automatic test_repeated_hits(input int hits);
    logic [ID_W-1:0] target;
    int              n;
    settle_frame();
    gaps_enabled = 1'b0;
    target       = frame_id[0];
    for (n = 0; n < hits; n++) offer_candidate(target);
    gaps_enabled = 1'b1;
  endtask

  // A short tail with a frame size of one once one slot holds a high count.
  task automatic test_small_frame_tail(input int items);
    int window_base;
    int n;
    program_frame_size(SIZE_W'(1));
    window_base = $urandom_range((1 << ID_W) - ID_WINDOW);
    for (n = 0; n < items; n++) offer_candidate(pick_candidate(window_base));
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fault_count++;
    end
  endtask

  // Result side: checks each accepted result transfer against the oldest prediction and
  // stalls at random. The values read here are those that the edge sampled.
  initial out_chan.ready = 1'b0;

  always @(posedge clk) begin : result_checker
    frame_outcome_t want;
    if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pred_tail == pred_head) begin
        $error("result transfer with no request outstanding: slot_index %0d",
               out_chan.slot_index);
        fault_count++;
      end else begin
        want = predicted_outcomes[pred_head % PRED_DEPTH];
        pred_head++;
        compare_field("hit", 32'(want.hit), 32'(out_chan.hit));
        compare_field("slot_index", 32'(want.slot_index), 32'(out_chan.slot_index));
        compare_field("evicted_valid", 32'(want.evicted_valid), 32'(out_chan.evicted_valid));
        compare_field("evicted_id", 32'(want.evicted_id), 32'(out_chan.evicted_id));
        compare_field("new_count", 32'(want.new_count), 32'(out_chan.new_count));
      end
    end
    out_chan.ready <= !gaps_enabled || ($urandom_range(99) >= 8);
  end

  // Main sequence. Reset is applied once only, so the frame never empties again: the tests
  // that depend on a small fill therefore run first, while the frame is still nearly empty.
  initial begin
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_chan.valid        = 1'b0;
    in_chan.candidate_id = '0;
    gaps_enabled         = 1'b1;
    fault_count          = 0;
    pred_head            = 0;
    pred_tail            = 0;
    frame_fill           = 0;
    frame_size_setting   = lfr_pkg::FRAME_SIZE_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      frame_id[i]    = '0;
      frame_votes[i] = '0;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_size_zero();
    test_tie_break();
    test_size_above_slots();
    test_size_below_occupancy();
    test_random_traffic(85);
    test_repeated_hits(40);
    test_small_frame_tail(30);
    settle_frame();

    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
